// ----- src/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants of the key matrix debouncer
// Holds the per-lane control bundle, register codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

  // Saturation ceiling of every key counter.
  localparam logic [7:0] COUNT_CEILING = 8'hFE;

  // Register reset values.
  localparam logic [7:0] THRESHOLD_RST = 8'd5;
  localparam logic [7:0] DISCARD_RST   = 8'd0;

  // Register index codes, taken from paddr[2].
  localparam logic REG_PRESS_THRESHOLD = 1'b0;
  localparam logic REG_DISCARD_FRAMES  = 1'b1;

  // Item kinds carried on the input tuser bit.
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Control bundle broadcast from the top level to every column lane.
  typedef struct packed {
    logic restart;  // clear all counters and stable bits
    logic update;   // write back the addressed row
    logic capture;  // adopt raw levels instead of integrating
  } kmd_ctrl_t;

endpackage

`default_nettype wire

// ----- src/key_matrix_debounce_top.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debounce_top: integrating debouncer for a scanned key matrix
// A result is registered and appears in the cycle after its item is taken.
// Throughput: one item per cycle unless the result channel stalls; the row
// read-modify-write in the lanes completes in the cycle the item is taken.
// Reset: synchronous, active low; clears all counters, debounced states,
// the discard count and the capture flag, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_top
  import kmd_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [1:0] row_index, [9:2] column_levels
  input  wire logic        in_tuser,   // [0] mode
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [1:0] out_row, [9:2] changed_mask,
                                       // [17:10] stable_mask
  output logic             out_tuser,  // [0] discarding
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. The register index is paddr[2]; writes land on
  // the access cycle of the transfer.
  // ---------------------------------------------------------------------------
  logic [7:0] threshold_r;
  logic [7:0] discard_cfg_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESHOLD_RST;
      discard_cfg_r <= DISCARD_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_PRESS_THRESHOLD: threshold_r   <= cfg_pwdata[7:0];
        REG_DISCARD_FRAMES:  discard_cfg_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_PRESS_THRESHOLD: cfg_prdata = {24'd0, threshold_r};
      REG_DISCARD_FRAMES:  cfg_prdata = {24'd0, discard_cfg_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input decode and handshake. The block takes a new item whenever the
  // output register is empty or is being drained in the same cycle.
  // ---------------------------------------------------------------------------
  logic            accept;
  logic            mode;
  logic [1:0]      row;
  logic [7:0]      levels;
  logic            restart;
  logic            in_range;
  logic            last_row;
  logic [RW-1:0]   ridx;
  logic [COLS-1:0] lane_levels;
  logic            out_valid;

  assign in_tready = ~out_valid | out_tready;
  assign accept    = in_tvalid & in_tready;

  assign mode     = in_tuser;
  assign row      = in_tdata[1:0];
  assign levels   = in_tdata[9:2];
  assign restart  = (mode == MODE_RESTART);
  assign in_range = (32'(row) < ROWS);
  assign last_row = (32'(row) == ROWS - 1);
  assign ridx     = RW'(row);

  // Columns past the eight input bits read as pressed (level zero).
  localparam int LW = (COLS > 8) ? COLS : 8;
  logic [LW-1:0] levels_w;
  assign levels_w    = LW'(levels);
  assign lane_levels = levels_w[COLS-1:0];

  // ---------------------------------------------------------------------------
  // Frame sequencing. After a restart, discard_left_r counts whole frames to
  // ignore; the frame after the last discarded one is the capture frame.
  // ---------------------------------------------------------------------------
  logic [7:0] discard_left_r, discard_left_nxt;
  logic       capture_r, capture_nxt;
  logic       discarding;
  kmd_ctrl_t  ctrl;

  assign discarding = (discard_left_r != 8'd0);

  always_comb begin
    discard_left_nxt = discard_left_r;
    capture_nxt      = capture_r;
    if (accept) begin
      if (restart) begin
        discard_left_nxt = discard_cfg_r;
        capture_nxt      = 1'b0;
      end else if (in_range) begin
        if (discarding) begin
          if (last_row) begin
            discard_left_nxt = discard_left_r - 8'd1;
            if (discard_left_r == 8'd1) begin
              capture_nxt = 1'b1;
            end
          end
        end else if (capture_r && last_row) begin
          capture_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_left_r <= 8'd0;
      capture_r      <= 1'b0;
    end else begin
      discard_left_r <= discard_left_nxt;
      capture_r      <= capture_nxt;
    end
  end

  assign ctrl.restart = accept & restart;
  assign ctrl.update  = accept & ~restart & in_range & ~discarding;
  assign ctrl.capture = capture_r;

  // ---------------------------------------------------------------------------
  // Column lanes: one per matrix column, each owning that column's keys.
  // ---------------------------------------------------------------------------
  logic [COLS-1:0] lane_changed;
  logic [COLS-1:0] lane_stable;

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    kmd_lane #(
      .ROWS (ROWS),
      .RW   (RW)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .row       (ridx),
      .level     (lane_levels[c]),
      .threshold (threshold_r),
      .changed   (lane_changed[c]),
      .stable    (lane_stable[c])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge the lane bits into the result item and register it.
  // ---------------------------------------------------------------------------
  logic [1:0] res_row;
  logic [7:0] res_changed;
  logic [7:0] res_stable;
  logic       res_discarding;

  kmd_merge #(
    .COLS (COLS)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .restart        (restart),
    .in_range       (in_range),
    .discard        (discarding),
    .row            (row),
    .lane_changed   (lane_changed),
    .lane_stable    (lane_stable),
    .take           (out_tready),
    .valid          (out_valid),
    .res_row        (res_row),
    .res_changed    (res_changed),
    .res_stable     (res_stable),
    .res_discarding (res_discarding)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {6'd0, res_stable, res_changed, res_row};
  assign out_tuser  = res_discarding;

endmodule

`default_nettype wire

// ----- src/kmd_lane.sv -----
// ----------------------------------------------------------------------------
// kmd_lane: one column of the key matrix
// Stores the counter and debounced state of this column's key in every row
// and updates the addressed row on in-range samples outside discard frames.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_lane
  import kmd_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int RW   = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kmd_ctrl_t     ctrl,
  input  wire logic [RW-1:0] row,
  input  wire logic          level,
  input  wire logic [7:0]    threshold,
  output logic               changed,
  output logic               stable
);

  logic [7:0] cnt_r [ROWS];
  logic       stb_r [ROWS];

  logic [7:0] cnt_cur;
  logic       stb_cur;
  logic       pressed;
  logic [7:0] cnt_step;
  logic [7:0] cnt_new;
  logic       stb_new;
  logic       chg_new;

  assign cnt_cur = cnt_r[row];
  assign stb_cur = stb_r[row];
  assign pressed = ~level;

  always_comb begin
    if (pressed) begin
      cnt_step = (cnt_cur < COUNT_CEILING) ? cnt_cur + 8'd1 : cnt_cur;
    end else begin
      cnt_step = (cnt_cur != 8'd0) ? cnt_cur - 8'd1 : cnt_cur;
    end

    cnt_new = cnt_step;
    stb_new = stb_cur;
    chg_new = 1'b0;
    if (ctrl.capture) begin
      cnt_new = pressed ? threshold : 8'd0;
      stb_new = pressed;
    end else if (!stb_cur && cnt_step >= threshold) begin
      stb_new = 1'b1;
      chg_new = 1'b1;
    end else if (stb_cur && cnt_step == 8'd0) begin
      stb_new = 1'b0;
      chg_new = 1'b1;
    end
  end

  assign changed = ctrl.update & chg_new;
  assign stable  = ctrl.update ? stb_new : stb_cur;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      for (int r = 0; r < ROWS; r++) begin
        cnt_r[r] <= 8'd0;
        stb_r[r] <= 1'b0;
      end
    end else if (ctrl.update) begin
      cnt_r[row] <= cnt_new;
      stb_r[row] <= stb_new;
    end
  end

endmodule

`default_nettype wire

// ----- src/kmd_merge.sv -----
// ----------------------------------------------------------------------------
// kmd_merge: result assembly and output register
// Gathers the lane bits into row masks, applies the item kind and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_merge
  import kmd_pkg::*;
#(
  parameter int COLS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            restart,
  input  wire logic            in_range,
  input  wire logic            discard,
  input  wire logic [1:0]      row,
  input  wire logic [COLS-1:0] lane_changed,
  input  wire logic [COLS-1:0] lane_stable,
  input  wire logic            take,
  output logic                 valid,
  output logic [1:0]           res_row,
  output logic [7:0]           res_changed,
  output logic [7:0]           res_stable,
  output logic                 res_discarding
);

  localparam int MW = (COLS > 8) ? COLS : 8;

  logic [MW-1:0] chg_w;
  logic [MW-1:0] stb_w;
  logic          valid_r, valid_nxt;
  logic [1:0]    row_r;
  logic [7:0]    chg_r;
  logic [7:0]    stb_r;
  logic          disc_r;

  assign chg_w = MW'(lane_changed);
  assign stb_w = MW'(lane_stable);

  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r  <= restart ? 2'd0 : row;
      chg_r  <= (restart || !in_range || discard) ? 8'd0 : chg_w[7:0];
      stb_r  <= (restart || !in_range) ? 8'd0 : stb_w[7:0];
      disc_r <= !restart && in_range && discard;
    end
  end

  assign valid          = valid_r;
  assign res_row        = row_r;
  assign res_changed    = chg_r;
  assign res_stable     = stb_r;
  assign res_discarding = disc_r;

endmodule

`default_nettype wire

// ----- src/kmd_checker.sv -----
// ----------------------------------------------------------------------------
// kmd_checker: port-level checks for the key matrix debouncer
// Watches the top level's channels and flags result items that break the
// block's timing or content rules.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Every taken item shows its result on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing one cycle after item");

  // A restart item yields an all-zero result.
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> out_tdata == 24'd0 && !out_tuser)
    else $error("restart result not zero");

  // Discarded items never report changes.
  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[9:2] == 8'd0)
    else $error("change reported during discard");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind key_matrix_debounce_top kmd_checker u_kmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
